// ===== rtl/bfc_pkg.sv =====
package bfc_pkg;

   localparam int PLANE_COUNT     = 6;
   localparam int COORD_WIDTH     = 16;
   localparam int REG_COUNT       = 6;
   localparam int COEF_WIDTH      = 16;
   localparam int PLANE_WIDTH     = 4 * COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PROD_WIDTH      = COEF_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int D_SHIFT         = 8;
   localparam int CELL_LATENCY    = 2;
   localparam int LATENCY         = CELL_LATENCY * PLANE_COUNT + 1;

   typedef enum logic [1:0] {
      CLASS_OUTSIDE      = 2'd0,
      CLASS_INTERSECTING = 2'd1,
      CLASS_INSIDE       = 2'd2
   } class_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] low_x;
      logic signed [COORD_WIDTH-1:0] low_y;
      logic signed [COORD_WIDTH-1:0] low_z;
      logic signed [COORD_WIDTH-1:0] high_x;
      logic signed [COORD_WIDTH-1:0] high_y;
      logic signed [COORD_WIDTH-1:0] high_z;
   } box_type;

   typedef struct packed {
      logic rejected;
      logic any_behind;
   } flags_type;

endpackage

// ===== rtl/bfc_cell.sv =====
module bfc_cell
   import bfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PLANE_WIDTH-1:0] plane,
   input  logic                   in_valid,
   input  box_type                in_box,
   input  flags_type              in_flags,
   output logic                   out_valid,
   output box_type                out_box,
   output flags_type              out_flags
);

   logic signed [COEF_WIDTH-1:0] nx, ny, nz, nd;

   // Stage one: the six coordinate products.
   logic                         s1_valid_ff;
   box_type                      s1_box_ff;
   flags_type                    s1_flags_ff;
   logic signed [COEF_WIDTH-1:0] s1_d_ff;
   logic signed [PROD_WIDTH-1:0] s1_lx_ff, s1_hx_ff, s1_ly_ff, s1_hy_ff, s1_lz_ff, s1_hz_ff;
   logic signed [PROD_WIDTH-1:0] s1_lx_in, s1_hx_in, s1_ly_in, s1_hy_in, s1_lz_in, s1_hz_in;

   // Stage two: the extreme corner sums and the updated flags.
   logic                         s2_valid_ff;
   box_type                      s2_box_ff;
   flags_type                    s2_flags_ff;
   flags_type                    s2_flags_in;

   logic signed [PROD_WIDTH-1:0] max_x, max_y, max_z, min_x, min_y, min_z;
   logic signed [SUM_WIDTH-1:0]  d_scaled, sum_max, sum_min;

   assign nx = plane[COEF_WIDTH-1:0];
   assign ny = plane[2*COEF_WIDTH-1:COEF_WIDTH];
   assign nz = plane[3*COEF_WIDTH-1:2*COEF_WIDTH];
   assign nd = plane[4*COEF_WIDTH-1:3*COEF_WIDTH];

   always_comb begin
      s1_lx_in = nx * in_box.low_x;
      s1_hx_in = nx * in_box.high_x;
      s1_ly_in = ny * in_box.low_y;
      s1_hy_in = ny * in_box.high_y;
      s1_lz_in = nz * in_box.low_z;
      s1_hz_in = nz * in_box.high_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_box_ff   <= in_box;
      s1_flags_ff <= in_flags;
      s1_d_ff     <= nd;
      s1_lx_ff    <= s1_lx_in;
      s1_hx_ff    <= s1_hx_in;
      s1_ly_ff    <= s1_ly_in;
      s1_hy_ff    <= s1_hy_in;
      s1_lz_ff    <= s1_lz_in;
      s1_hz_ff    <= s1_hz_in;
   end

   // The plane sum separates by axis, so the largest and smallest sums over the
   // eight corners come from picking per axis. All corners are behind exactly
   // when the largest sum is negative, and some corner is behind exactly when
   // the smallest sum is negative.
   always_comb begin
      max_x    = (s1_lx_ff > s1_hx_ff) ? s1_lx_ff : s1_hx_ff;
      min_x    = (s1_lx_ff > s1_hx_ff) ? s1_hx_ff : s1_lx_ff;
      max_y    = (s1_ly_ff > s1_hy_ff) ? s1_ly_ff : s1_hy_ff;
      min_y    = (s1_ly_ff > s1_hy_ff) ? s1_hy_ff : s1_ly_ff;
      max_z    = (s1_lz_ff > s1_hz_ff) ? s1_lz_ff : s1_hz_ff;
      min_z    = (s1_lz_ff > s1_hz_ff) ? s1_hz_ff : s1_lz_ff;
      d_scaled = SUM_WIDTH'(s1_d_ff) <<< D_SHIFT;
      sum_max  = SUM_WIDTH'(max_x) + SUM_WIDTH'(max_y) + SUM_WIDTH'(max_z) + d_scaled;
      sum_min  = SUM_WIDTH'(min_x) + SUM_WIDTH'(min_y) + SUM_WIDTH'(min_z) + d_scaled;
      s2_flags_in.rejected   = s1_flags_ff.rejected | sum_max[SUM_WIDTH-1];
      s2_flags_in.any_behind = s1_flags_ff.any_behind | sum_min[SUM_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_box_ff   <= s1_box_ff;
      s2_flags_ff <= s2_flags_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_box   = s2_box_ff;
   assign out_flags = s2_flags_ff;

endmodule

// ===== rtl/box_frustum_classifier_top.sv =====
// Classifies one axis-aligned box per cycle against the frustum planes held in
// the csr_ registers: 0 outside, 1 intersecting, 2 fully inside. A box is taken
// in every cycle in which start is high (busy is always low), and its result
// appears on rsp_classification with rsp_valid high for one cycle, after it has
// passed through the row of plane cells, one per plane, each with a multiply
// stage and a sum-and-compare stage, and then through the output register.
// Results leave in the order the boxes came in. Plane registers reset to zero,
// which rejects no corner; write them only while no box is in flight.
module box_frustum_classifier_top
   import bfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_WIDTH-1:0] req_low_x,
   input  logic signed [COORD_WIDTH-1:0] req_low_y,
   input  logic signed [COORD_WIDTH-1:0] req_low_z,
   input  logic signed [COORD_WIDTH-1:0] req_high_x,
   input  logic signed [COORD_WIDTH-1:0] req_high_y,
   input  logic signed [COORD_WIDTH-1:0] req_high_z,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_classification,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [PLANE_WIDTH-1:0]     csr_write_data
);

   logic [PLANE_WIDTH-1:0] plane_ff [PLANE_COUNT];

   logic      chain_valid [PLANE_COUNT+1];
   box_type   chain_box   [PLANE_COUNT+1];
   flags_type chain_flags [PLANE_COUNT+1];

   logic      rsp_valid_ff;
   class_type rsp_class_ff;
   class_type rsp_class_in;

   assign busy = 1'b0;

   // Planes past the register list are never written and stay zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (csr_write_enable && (i < REG_COUNT) &&
                (csr_index == CSR_INDEX_WIDTH'(i))) begin
               plane_ff[i] <= csr_write_data;
            end
         end
      end
   end

   assign chain_valid[0]            = start;
   assign chain_box[0].low_x        = req_low_x;
   assign chain_box[0].low_y        = req_low_y;
   assign chain_box[0].low_z        = req_low_z;
   assign chain_box[0].high_x       = req_high_x;
   assign chain_box[0].high_y       = req_high_y;
   assign chain_box[0].high_z       = req_high_z;
   assign chain_flags[0].rejected   = 1'b0;
   assign chain_flags[0].any_behind = 1'b0;

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      bfc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (plane_ff[p]),
         .in_valid  (chain_valid[p]),
         .in_box    (chain_box[p]),
         .in_flags  (chain_flags[p]),
         .out_valid (chain_valid[p+1]),
         .out_box   (chain_box[p+1]),
         .out_flags (chain_flags[p+1])
      );
   end

   always_comb begin
      if (chain_flags[PLANE_COUNT].rejected) begin
         rsp_class_in = CLASS_OUTSIDE;
      end else if (chain_flags[PLANE_COUNT].any_behind) begin
         rsp_class_in = CLASS_INTERSECTING;
      end else begin
         rsp_class_in = CLASS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[PLANE_COUNT];
      end
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_classification = rsp_class_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result at the expected latency");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching accepted transaction");

   a_legal_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_classification == CLASS_OUTSIDE ||
                     rsp_classification == CLASS_INTERSECTING ||
                     rsp_classification == CLASS_INSIDE))
      else $error("result carries an undefined classification");

endmodule

// ===== tb/sv/box_frustum_classifier_top_tb.sv =====
`timescale 1ns / 1ps

module box_frustum_classifier_top_tb;
   import bfc_pkg::*;

   localparam int CORNER_COUNT = 8;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_BOXES_PER_SETTING = 92;

   // Coefficient values at the edges of the signed Q8.8 range, plus zero and plus and minus one LSB.
   localparam logic [COEF_WIDTH-1:0] EXTREME_COEFS [5] =
      '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

   typedef enum int {
      CFG_SLAB,
      CFG_TILTED,
      CFG_RANDOM,
      CFG_EXTREME,
      CFG_SPARSE
   } plane_setting_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [COORD_WIDTH-1:0] req_low_x;
   logic signed [COORD_WIDTH-1:0] req_low_y;
   logic signed [COORD_WIDTH-1:0] req_low_z;
   logic signed [COORD_WIDTH-1:0] req_high_x;
   logic signed [COORD_WIDTH-1:0] req_high_y;
   logic signed [COORD_WIDTH-1:0] req_high_z;
   logic                          rsp_valid;
   logic [1:0]                    rsp_classification;
   logic                          csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [PLANE_WIDTH-1:0]        csr_write_data;

   logic [PLANE_WIDTH-1:0] plane_cfg [REG_COUNT] = '{default: '0};
   class_type              expected_classes [$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     burst_left  = 0;

   box_frustum_classifier_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_low_x          (req_low_x),
      .req_low_y          (req_low_y),
      .req_low_z          (req_low_z),
      .req_high_x         (req_high_x),
      .req_high_y         (req_high_y),
      .req_high_z         (req_high_z),
      .rsp_valid          (rsp_valid),
      .rsp_classification (rsp_classification),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("box_frustum_classifier_top test failed");
         $finish;
      end
   end

   // Classification of a box against the planes currently held in plane_cfg.
   function automatic class_type classify_box(input box_type b);
      logic [PLANE_WIDTH-1:0] pl;
      longint nx, ny, nz, dd, x, y, z;
      int     behind;
      bit     rejected;
      bit     any_behind;
      rejected   = 1'b0;
      any_behind = 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         pl = (p < REG_COUNT) ? plane_cfg[p] : '0;
         nx = $signed(pl[0 +: COEF_WIDTH]);
         ny = $signed(pl[COEF_WIDTH +: COEF_WIDTH]);
         nz = $signed(pl[2*COEF_WIDTH +: COEF_WIDTH]);
         dd = $signed(pl[3*COEF_WIDTH +: COEF_WIDTH]);
         behind = 0;
         for (int c = 0; c < CORNER_COUNT; c++) begin
            x = c[2] ? b.high_x : b.low_x;
            y = c[1] ? b.high_y : b.low_y;
            z = c[0] ? b.high_z : b.low_z;
            if (nx * x + ny * y + nz * z + (dd <<< D_SHIFT) < 0) begin
               behind++;
            end
         end
         if (behind == CORNER_COUNT) rejected = 1'b1;
         if (behind != 0) any_behind = 1'b1;
      end
      if (rejected) return CLASS_OUTSIDE;
      else if (any_behind) return CLASS_INTERSECTING;
      else return CLASS_INSIDE;
   endfunction

   function automatic logic [PLANE_WIDTH-1:0] pack_plane(input int nx, input int ny,
                                                         input int nz, input int dd);
      logic [COEF_WIDTH-1:0] cx, cy, cz, cd;
      cx = COEF_WIDTH'(nx);
      cy = COEF_WIDTH'(ny);
      cz = COEF_WIDTH'(nz);
      cd = COEF_WIDTH'(dd);
      return {cd, cz, cy, cx};
   endfunction

   function automatic box_type make_box(input int lx, input int ly, input int lz,
                                        input int hx, input int hy, input int hz);
      box_type b;
      b.low_x  = COORD_WIDTH'(lx);
      b.low_y  = COORD_WIDTH'(ly);
      b.low_z  = COORD_WIDTH'(lz);
      b.high_x = COORD_WIDTH'(hx);
      b.high_y = COORD_WIDTH'(hy);
      b.high_z = COORD_WIDTH'(hz);
      return b;
   endfunction

   // Mostly moderate boxes near the planes, some over the full range, some inverted.
   function automatic box_type random_box();
      int pick;
      int cx, cy, cz, hx, hy, hz;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         return box_type'({$urandom(), $urandom(), $urandom()});
      end
      cx = int'($urandom_range(0, 3600)) - 1800;
      cy = int'($urandom_range(0, 3600)) - 1800;
      cz = int'($urandom_range(0, 3600)) - 1800;
      hx = $urandom_range(0, 700);
      hy = $urandom_range(0, 700);
      hz = $urandom_range(0, 700);
      if (pick >= 86) begin
         // Low corner above the high one on x, and on y now and then.
         if ($urandom_range(0, 1) == 0) hy = -hy;
         return make_box(cx + hx, cy - hy, cz - hz, cx - hx, cy + hy, cz + hz);
      end
      return make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
   endfunction

   // The handshake: the transaction completes at the first edge with busy low.
   task automatic send_box(input box_type b);
      start      <= 1'b1;
      req_low_x  <= b.low_x;
      req_low_y  <= b.low_y;
      req_low_z  <= b.low_z;
      req_high_x <= b.high_x;
      req_high_y <= b.high_y;
      req_high_z <= b.high_z;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_classes.push_back(classify_box(b));
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 3) == 0) idle_for($urandom_range(9, 20));
         else idle_for($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_classes.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // The enable stays high across back-to-back writes; end_csr_writes lowers it.
   task automatic write_csr(input int idx, input logic [PLANE_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_INDEX_WIDTH'(idx);
      csr_write_data   <= data;
      @(posedge clock);
      if (idx < REG_COUNT) plane_cfg[idx] = data;
   endtask

   task automatic end_csr_writes();
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_planes(input plane_setting_type setting);
      logic [PLANE_WIDTH-1:0] value;
      int n [3];
      int dd;
      int axis;
      for (int p = 0; p < REG_COUNT; p++) begin
         case (setting)
            CFG_RANDOM: begin
               value = {$urandom(), $urandom()};
            end
            CFG_EXTREME: begin
               value = {EXTREME_COEFS[$urandom_range(0, 4)], EXTREME_COEFS[$urandom_range(0, 4)],
                        EXTREME_COEFS[$urandom_range(0, 4)], EXTREME_COEFS[$urandom_range(0, 4)]};
            end
            default: begin
               // Even planes bound an axis from below, odd planes from above.
               axis = p / 2;
               n = '{0, 0, 0};
               n[axis] = (p % 2 == 0) ? 256 : -256;
               dd = $urandom_range(100, 1500);
               if (setting == CFG_TILTED) begin
                  foreach (n[k]) n[k] += int'($urandom_range(0, 96)) - 48;
                  dd += int'($urandom_range(0, 64)) - 32;
               end
               value = pack_plane(n[0], n[1], n[2], dd);
               if (setting == CFG_SPARSE && $urandom_range(0, 2) == 0) value = '0;
            end
         endcase
         write_csr(p, value);
      end
      if ($urandom_range(0, 1) == 0) begin
         write_csr(REG_COUNT + $urandom_range(0, 1), {$urandom(), $urandom()});
      end
      end_csr_writes();
   endtask

   // With every plane zero, no corner is behind anything, whatever the box.
   task automatic test_zero_planes();
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      wait_until_drained();
   endtask

   // A cube frustum about the origin; writes past the last plane register must not land.
   task automatic test_cube_planes();
      write_csr(0, pack_plane(256, 0, 0, 256));
      write_csr(1, pack_plane(-256, 0, 0, 256));
      write_csr(2, pack_plane(0, 256, 0, 256));
      write_csr(3, pack_plane(0, -256, 0, 256));
      write_csr(4, pack_plane(0, 0, 256, 256));
      write_csr(5, pack_plane(0, 0, -256, 256));
      write_csr(REG_COUNT, 64'h8000_8000_8000_8000);
      write_csr(REG_COUNT + 1, 64'h8000_8000_8000_8000);
      end_csr_writes();
      send_box(make_box(-128, -128, -128, 128, 128, 128));
      send_box(make_box(100, -100, -100, 400, 100, 100));
      send_box(make_box(600, 0, 0, 800, 100, 100));
      // The last plane rejects the box; the x and y planes only cut it.
      send_box(make_box(-1000, -1000, 300, 1000, 1000, 400));
      send_box(make_box(200, 200, 200, -200, -200, -200));
      send_box(make_box(400, 0, 0, -400, 0, 0));
      send_box(make_box(-256, -256, -256, 256, 256, 256));
      wait_until_drained();
   endtask

   task automatic test_extreme_planes();
      write_csr(0, 64'h8000_8000_8000_8000);
      write_csr(1, 64'h7FFF_7FFF_7FFF_7FFF);
      write_csr(2, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(3, '0);
      write_csr(4, '0);
      write_csr(5, '0);
      end_csr_writes();
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767));
      wait_until_drained();
   endtask

   task automatic test_random_boxes();
      plane_setting_type settings [6] =
         '{CFG_SLAB, CFG_TILTED, CFG_RANDOM, CFG_EXTREME, CFG_SPARSE, CFG_SLAB};
      foreach (settings[i]) begin
         configure_planes(settings[i]);
         burst_left = $urandom_range(0, 12);
         repeat (RANDOM_BOXES_PER_SETTING) begin
            send_box(random_box());
            pace_sender();
         end
         wait_until_drained();
      end
   endtask

   always @(posedge clock) begin
      class_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_classes.size() == 0) begin
            $display("%0t: result with no box outstanding: expected none, actual %0d",
                     $time, rsp_classification);
            error_count++;
         end else begin
            want = expected_classes.pop_front();
            if (rsp_classification !== want) begin
               $display("%0t: classification mismatch: expected %0d (%s), actual %0d",
                        $time, want, want.name(), rsp_classification);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_low_x        <= '0;
      req_low_y        <= '0;
      req_low_z        <= '0;
      req_high_x       <= '0;
      req_high_y       <= '0;
      req_high_z       <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_zero_planes();
      test_cube_planes();
      test_extreme_planes();
      test_random_boxes();

      if (error_count == 0) begin
         $display("box_frustum_classifier_top test passed");
      end else begin
         $display("box_frustum_classifier_top test failed");
      end
      $finish;
   end

endmodule
